>>> rtl/core/sta_pkg.sv
`timescale 1ns / 1ps

package sta_pkg;

    localparam int DEFAULT_NUM_SLOTS = 8;

    localparam int ID_W     = 16;
    localparam int CD_W     = 8;
    localparam int RELOAD_W = 7;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int EXP_W    = 4;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 7'd10;
    localparam logic [CD_W-1:0]     CD_FREE      = 8'hFF;
    localparam logic [CD_W-1:0]     CD_EXPIRING  = 8'd1;
    localparam logic [EXP_W-1:0]    EXP_MAX      = 4'd15;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TICK = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [CD_W-1:0] cd;
    } entry_t;

    localparam entry_t FREE_ENTRY = '{id: '0, cd: CD_FREE};

    typedef struct packed {
        logic [EXP_W-1:0]    expired_count;
        logic [SLOT_W-1:0]   slot_index;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

>>> rtl/core/sta_table.sv
`timescale 1ns / 1ps

module sta_table import sta_pkg::*; #(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t                 mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   vld_reg;
    entry_t                 rd_q_reg;
    logic                   rd_vld_reg;

    // Entries never written since reset read back as free with ID 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg   <= mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : FREE_ENTRY;

endmodule

>>> rtl/core/sta_seq.sv
`timescale 1ns / 1ps

module sta_seq import sta_pkg::*; #(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [ID_W-1:0]     in_id,
    input  logic [RELOAD_W-1:0] reload,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output entry_t              wr_data,
    output logic [IDX_W-1:0]    rd_addr,
    input  entry_t              rd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic             cmd_reg, cmd_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] wptr_reg, wptr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_pos_reg, free_pos_next;
    logic [EXP_W-1:0] removed_reg, removed_next;
    result_t          res_reg, res_next;
    logic [IDX_W-1:0] target;

    assign target = found_reg ? pos_reg : free_pos_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        wptr_next       = wptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        free_found_next = free_found_reg;
        free_pos_next   = free_pos_reg;
        removed_next    = removed_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = wptr_reg[IDX_W-1:0];
        wr_data         = FREE_ENTRY;
        rd_addr         = cnt_reg[IDX_W-1:0];
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_DONE);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next        = in_cmd;
                    id_next         = in_id;
                    cnt_next        = '0;
                    wptr_next       = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next     = (cnt_reg < CNT_END);
                pend_idx_next = cnt_reg[IDX_W-1:0];
                if (cnt_reg < CNT_END) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (cmd_reg == CMD_REGISTER) begin
                        if (!found_reg && rd_data.id == id_reg) begin
                            found_next = 1'b1;
                            pos_next   = pend_idx_reg;
                        end
                        if (!free_found_reg && rd_data.cd == CD_FREE) begin
                            free_found_next = 1'b1;
                            free_pos_next   = pend_idx_reg;
                        end
                    end else if (rd_data.cd == CD_EXPIRING) begin
                        if (removed_reg != EXP_MAX) begin
                            removed_next = removed_reg + 1'b1;
                        end
                    end else begin
                        // Surviving entries are packed down toward index zero.
                        wr_en      = 1'b1;
                        wr_data.id = rd_data.id;
                        wr_data.cd = rd_data.cd[CD_W-1] ? rd_data.cd : rd_data.cd - 1'b1;
                        wptr_next  = wptr_reg + 1'b1;
                    end
                end
                if (cnt_reg == CNT_END && !pend_reg) begin
                    state_next = (cmd_reg == CMD_TICK) ? ST_FILL : ST_FINISH;
                end
            end
            ST_FINISH: begin
                res_next.expired_count = '0;
                if (found_reg || free_found_reg) begin
                    wr_en               = 1'b1;
                    wr_addr             = target;
                    wr_data.id          = id_reg;
                    wr_data.cd          = {1'b0, reload};
                    res_next.status     = STATUS_OK;
                    res_next.slot_index = SLOT_W'(target);
                end else begin
                    res_next.status     = STATUS_FULL;
                    res_next.slot_index = '0;
                end
                state_next = ST_DONE;
            end
            ST_FILL: begin
                if (wptr_reg < CNT_END) begin
                    wr_en     = 1'b1;
                    wptr_next = wptr_reg + 1'b1;
                end else begin
                    res_next.status        = STATUS_TICK;
                    res_next.slot_index    = '0;
                    res_next.expired_count = removed_reg;
                    state_next             = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        cnt_reg        <= cnt_next;
        wptr_reg       <= wptr_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        free_found_reg <= free_found_next;
        free_pos_reg   <= free_pos_next;
        removed_reg    <= removed_next;
        res_reg        <= res_next;
    end

endmodule

>>> rtl/core/slot_table_with_aging_core.sv
`timescale 1ns / 1ps

// Aging slot table with NUM_SLOTS entries, each a 16-bit device ID and a countdown.
// Input words arrive on the s_ channel: tuser carries the command (register or tick),
// tdata the device ID. Each input word yields exactly one result word on the m_ channel:
// tuser carries the status, tdata the slot index and the expired count.
// Every word is handled by one sequencer that scans the table memory one entry per cycle
// through its single read port, whose read data is registered.
// A register command scans the table and then writes the entry it found or a free one.
// A tick command scans the table, packing survivors, and then rewrites the freed tail
// of the table with free entries one entry per cycle.
// s_tready is high only while no word is in progress, so one word is handled at a time.
// The result sits in an output register; a stalled receiver only blocks the block once
// the next result is ready and the register is still full.
// The user must write the timeout reload through cfg_we and cfg_wdata only while idle.
// The block itself does not enforce this. After reset all entries are free with ID 0,
// the reload is 10, and no result is pending. No clearing pass is needed after reset.
module slot_table_with_aging_core import sta_pkg::*; #(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [RELOAD_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] device_id
    input  logic [0:0]          s_tuser,   // [0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [2:0] slot_index, [6:3] expired_count, [7] zero
    output logic [1:0]          m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [RELOAD_W-1:0] reload_reg, reload_next;
    logic                m_tvalid_reg, m_tvalid_next;
    result_t             m_res_reg, m_res_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;
    logic [IDX_W-1:0]    rd_addr;
    entry_t              rd_data;
    logic                res_valid;
    logic                res_ready;
    result_t             res;

    sta_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sta_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[0]),
        .in_id     (s_tdata),
        .reload    (reload_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        reload_next   = reload_reg;
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (cfg_we) begin
            reload_next = cfg_wdata;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg   <= RELOAD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            reload_reg   <= reload_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.expired_count, m_res_reg.slot_index};
    assign m_tuser  = m_res_reg.status;

endmodule

>>> sim/tb_slot_table_with_aging_core.sv
`timescale 1ns / 1ps

module tb_slot_table_with_aging_core;
    import sta_pkg::*;

    localparam int NUM_SLOTS = DEFAULT_NUM_SLOTS;
    localparam int ID_POOL_N = 12;

    class slot_scoreboard;
        logic [ID_W-1:0]     ids [NUM_SLOTS];
        logic [CD_W-1:0]     cds [NUM_SLOTS];
        logic [RELOAD_W-1:0] reload_value;
        result_t             pending_results [$];
        int                  mismatches;

        function new();
            for (int k = 0; k < NUM_SLOTS; k++) begin
                ids[k] = '0;
                cds[k] = CD_FREE;
            end
            reload_value = RELOAD_RESET;
            mismatches = 0;
        endfunction

        function result_t predict_result(logic cmd, logic [ID_W-1:0] id);
            result_t r;
            int pos;
            int removed;
            r = '0;
            if (cmd == CMD_REGISTER) begin
                pos = NUM_SLOTS;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (pos == NUM_SLOTS && ids[k] == id) pos = k;
                end
                if (pos == NUM_SLOTS) begin
                    for (int k = 0; k < NUM_SLOTS; k++) begin
                        if (pos == NUM_SLOTS && cds[k] == CD_FREE) begin
                            ids[k] = id;
                            pos = k;
                        end
                    end
                end
                if (pos < NUM_SLOTS) begin
                    cds[pos] = {1'b0, reload_value};
                    r.status = STATUS_OK;
                    r.slot_index = SLOT_W'(pos);
                end else begin
                    r.status = STATUS_FULL;
                end
            end else begin
                removed = 0;
                for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
                    if (!cds[k][CD_W-1]) cds[k] = cds[k] - 1'b1;
                    if (cds[k] == '0) begin
                        for (int j = k; j < NUM_SLOTS - 1; j++) begin
                            ids[j] = ids[j+1];
                            cds[j] = cds[j+1];
                        end
                        ids[NUM_SLOTS-1] = '0;
                        cds[NUM_SLOTS-1] = CD_FREE;
                        removed++;
                    end
                end
                r.status = STATUS_TICK;
                r.expired_count = (removed > EXP_MAX) ? EXP_MAX : EXP_W'(removed);
            end
            return r;
        endfunction

        function void note_request(logic cmd, logic [ID_W-1:0] id);
            pending_results.push_back(predict_result(cmd, id));
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [7:0] data);
            result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d data %h", status, data);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || data[2:0] !== want.slot_index
                    || data[6:3] !== want.expired_count || data[7] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected status %0d slot %0d expired %0d, %s %0d %0d %0d pad %b",
                             want.status, want.slot_index, want.expired_count,
                             "got", status, data[2:0], data[6:3], data[7]);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [RELOAD_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;
    logic [1:0]          m_tuser;

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;

    slot_scoreboard sb = new();

    logic [ID_W-1:0] id_pool [ID_POOL_N] = '{
        16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
        16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F, 16'h7FFE, 16'h4000
    };

    slot_table_with_aging_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_word(input logic cmd, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= id;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(cmd, id);
    endtask

    task automatic send_random_word();
        logic            cmd;
        logic [ID_W-1:0] id;
        cmd = ($urandom_range(99) < 30) ? CMD_TICK : CMD_REGISTER;
        if ($urandom_range(99) < 80)
            id = id_pool[$urandom_range(ID_POOL_N - 1)];
        else
            id = ID_W'($urandom);
        send_word(cmd, id);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_reload(input logic [RELOAD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.reload_value = value;
    endtask

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [RELOAD_W-1:0] reload_next;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_REGISTER;
        send_idle_pct = 31;
        recv_idle_pct = 70;
        recv_hold = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ID zero matches the free entry zero; the table then fills up and overflows.
        send_word(CMD_REGISTER, 16'h0000);
        send_word(CMD_REGISTER, 16'hFFFF);
        send_word(CMD_REGISTER, 16'h0000);
        send_word(CMD_REGISTER, 16'h0001);
        send_word(CMD_REGISTER, 16'h0002);
        send_word(CMD_REGISTER, 16'h0004);
        send_word(CMD_REGISTER, 16'h0008);
        send_word(CMD_REGISTER, 16'h8000);
        send_word(CMD_REGISTER, 16'h5555);
        send_word(CMD_REGISTER, 16'hAAAA);
        send_word(CMD_TICK, 16'hFFFF);
        send_word(CMD_REGISTER, 16'h8000);

        // A reload of one makes the next tick remove entries.
        wait_drained();
        set_reload(7'd1);
        send_word(CMD_REGISTER, 16'h0004);
        send_word(CMD_REGISTER, 16'h0001);
        send_word(CMD_TICK, 16'h0000);

        // A reload of zero frees the entry in place on the next tick.
        wait_drained();
        set_reload(7'd0);
        send_word(CMD_REGISTER, 16'h1357);
        send_word(CMD_TICK, 16'h0000);
        send_word(CMD_REGISTER, 16'h1357);
        send_word(CMD_REGISTER, 16'h2468);

        wait_drained();
        set_reload(7'd127);
        send_word(CMD_TICK, 16'h0000);
        send_word(CMD_REGISTER, 16'hFFFF);
        send_word(CMD_TICK, 16'h0000);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 4; sub++) begin
                case (sub)
                    0: reload_next = 7'd1;
                    1: reload_next = RELOAD_W'($urandom_range(2, 5));
                    2: reload_next = (phase == 0) ? 7'd127 : (phase == 1) ? 7'd0 : 7'd3;
                    default: reload_next = RELOAD_W'($urandom_range(0, 127));
                endcase
                wait_drained();
                set_reload(reload_next);
                if (phase == 0 && sub == 1) recv_hold = 250;
                for (int n = 0; n < 54; n++) begin
                    if (phase == 1 && sub == 1 && n == 27) wait_drained();
                    send_random_word();
                end
            end
        end

        wait_drained();
        repeat (NUM_SLOTS + 12) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
